[sv/assert_macros.svh]
// Assertion helpers for the RTL files; lsvg_post includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/lsvg_pkg.sv]
// ----------------------------------------------------------------------------
// lsvg_pkg
// Types, constants and helpers of the lat-long sphere vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsvg_pkg;

  // Largest ring count; index fields are sized for it
  localparam int SEG_MAX = 256;

  // Divider: remainder width and quotient bits per lane
  localparam int DW = 42;
  localparam int QW = 33;
  // CORDIC datapath widths
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int PW = 61;
  localparam int STEPS = 30;
  localparam int NRW = 34;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [CW-1:0] GAIN_Q30 = CW'(652032875);
  localparam logic [CW-1:0] ONE_Q30 = CW'(1073741824);
  localparam logic [16:0] TEX_HALF = 17'd32768;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_SEG_COUNT = 3'd4;
  localparam logic [2:0] REG_TEX_EN = 3'd5;

  // Divider cell contents: lanes are ring phase, segment phase, tex s, tex t
  typedef struct packed {
    logic [3:0][DW-1:0] rem;
    logic [3:0][QW-1:0] quo;
    logic [8:0] n;
    logic err;
    logic pole;
  } div_t;

  // After the divider: phase split and angle product
  typedef struct packed {
    logic [1:0][1:0] quad;
    logic [1:0] zero;
    logic [1:0][PW-1:0] zprod;
    logic [16:0] ts;
    logic [16:0] tt;
    logic err;
    logic pole;
  } prep_t;

  // CORDIC cell contents, lane 0 ring angle, lane 1 segment angle
  typedef struct packed {
    logic [1:0][CW-1:0] x;
    logic [1:0][CW-1:0] y;
    logic [1:0][ZW-1:0] z;
    logic [1:0][1:0] quad;
    logic [1:0] zero;
    logic [16:0] ts;
    logic [16:0] tt;
    logic err;
    logic pole;
  } cord_t;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
    logic tex_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0][15:0] nrm;
    logic [2:0][31:0] pos;
    logic [16:0] ts;
    logic [16:0] tt;
    logic err;
    logic pole;
  } res_t;

  // Arctangent of 2^-i in Q2.30 radians
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    unique case (i)
      0: a = 32'd843314857;
      1: a = 32'd497837830;
      2: a = 32'd263043837;
      3: a = 32'd133525159;
      4: a = 32'd67021687;
      5: a = 32'd33543516;
      6: a = 32'd16775851;
      7: a = 32'd8388437;
      8: a = 32'd4194283;
      9: a = 32'd2097149;
      default: a = (i < 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return a;
  endfunction

  // Shift right, rounding half away from zero
  function automatic logic signed [71:0] rsh(input logic signed [71:0] v,
                                             input int unsigned sh);
    logic signed [71:0] half;
    logic signed [71:0] a;
    half = 72'sd1 <<< (sh - 1);
    a = -v;
    if (!v[71]) begin
      return (v + half) >>> sh;
    end else begin
      return -((a + half) >>> sh);
    end
  endfunction

endpackage

[sv/lsvg_div_cell.sv]
// ----------------------------------------------------------------------------
// lsvg_div_cell
// One quotient bit of four restoring divisions, registered with a handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsvg_div_cell
  import lsvg_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic v_r;
  div_t d_r;
  div_t d_nxt;

  // Subtract the shifted divisor where it fits
  always_comb begin
    logic [9:0] dv;
    logic [DW-1:0] dsh;
    logic [DW:0] diff;
    d_nxt = in_data;
    for (int l = 0; l < 4; l++) begin
      dv = (l == 2) ? {in_data.n, 1'b0} : {1'b0, in_data.n};
      dsh = DW'(dv) << BIT;
      diff = {1'b0, in_data.rem[l]} - {1'b0, dsh};
      if (!diff[DW]) begin
        d_nxt.rem[l] = diff[DW-1:0];
        d_nxt.quo[l][BIT] = 1'b1;
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  // Advance the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data = d_r;

endmodule

[sv/lsvg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// lsvg_cordic_cell
// One rotation step of two CORDIC lanes, registered with a handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsvg_cordic_cell
  import lsvg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cord_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cord_t out_data
);

  localparam logic [ZW-1:0] ATAN = ZW'(atan_q30(STEP));

  logic v_r;
  cord_t d_r;
  cord_t d_nxt;

  // Rotate toward zero residual angle
  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    d_nxt = in_data;
    for (int l = 0; l < 2; l++) begin
      xs = $signed(in_data.x[l]);
      ys = $signed(in_data.y[l]);
      dx = ys >>> STEP;
      dy = xs >>> STEP;
      if (!in_data.z[l][ZW-1]) begin
        d_nxt.x[l] = xs - dx;
        d_nxt.y[l] = ys + dy;
        d_nxt.z[l] = in_data.z[l] - ATAN;
      end else begin
        d_nxt.x[l] = xs + dx;
        d_nxt.y[l] = ys - dy;
        d_nxt.z[l] = in_data.z[l] + ATAN;
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data = d_r;

endmodule

[sv/lsvg_post.sv]
// ----------------------------------------------------------------------------
// lsvg_post
// Quadrant mapping, normal products, scaling by radius and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsvg_post
  import lsvg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  cord_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

`include "assert_macros.svh"

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [2*CW-1:0] px_r, pz_r, px_nxt, pz_nxt;
  logic signed [CW-1:0] sinlat1_r, sinlat_nxt;
  logic signed [NRW-1:0] n2_r [3];
  logic signed [NRW-1:0] n3_r [3];
  logic signed [65:0] pr3_r [3];
  logic [16:0] ts1_r, ts2_r, ts3_r, tt1_r, tt2_r, tt3_r;
  logic err1_r, err2_r, err3_r, pole1_r, pole2_r, pole3_r;
  res_t res_r;
  res_t res_nxt;

  // Stage ready chain
  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Map quadrants and form the cos(lat) products
  always_comb begin
    logic signed [CW-1:0] x, y, co0, si0, co1, si1;
    co0 = '0; si0 = '0; co1 = '0; si1 = '0;
    for (int l = 0; l < 2; l++) begin
      x = in_data.zero[l] ? $signed(ONE_Q30) : $signed(in_data.x[l]);
      y = in_data.zero[l] ? '0 : $signed(in_data.y[l]);
      unique case (in_data.quad[l])
        2'd0: begin
          if (l == 0) begin co0 = x; si0 = y; end else begin co1 = x; si1 = y; end
        end
        2'd1: begin
          if (l == 0) begin co0 = -y; si0 = x; end else begin co1 = -y; si1 = x; end
        end
        2'd2: begin
          if (l == 0) begin co0 = -x; si0 = -y; end else begin co1 = -x; si1 = -y; end
        end
        default: begin
          if (l == 0) begin co0 = y; si0 = -x; end else begin co1 = y; si1 = -x; end
        end
      endcase
    end
    sinlat_nxt = -co0;
    px_nxt = si1 * si0;
    pz_nxt = co1 * si0;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      px_r <= px_nxt;
      pz_r <= pz_nxt;
      sinlat1_r <= sinlat_nxt;
      ts1_r <= in_data.ts;
      tt1_r <= in_data.tt;
      err1_r <= in_data.err;
      pole1_r <= in_data.pole;
    end
  end

  // Round products to Q30 normals
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      n2_r[0] <= NRW'(rsh(-(72'(px_r)), 30));
      n2_r[1] <= NRW'(sinlat1_r);
      n2_r[2] <= NRW'(rsh(-(72'(pz_r)), 30));
      ts2_r <= ts1_r;
      tt2_r <= tt1_r;
      err2_r <= err1_r;
      pole2_r <= pole1_r;
    end
  end

  // Scale normals by the radius
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int k = 0; k < 3; k++) begin
        pr3_r[k] <= $signed({1'b0, cfg.radius}) * n2_r[k];
        n3_r[k] <= n2_r[k];
      end
      ts3_r <= ts2_r;
      tt3_r <= tt2_r;
      err3_r <= err2_r;
      pole3_r <= pole2_r;
    end
  end

  // Round, add the center and saturate
  always_comb begin
    logic signed [71:0] s;
    logic signed [31:0] c;
    res_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      c = (k == 0) ? $signed(cfg.center_x) :
          (k == 1) ? $signed(cfg.center_y) : $signed(cfg.center_z);
      s = 72'(c) + rsh(72'(pr3_r[k]), 30);
      if (s > 72'sd2147483647) begin
        res_nxt.pos[k] = 32'h7fffffff;
      end else if (s < -72'sd2147483648) begin
        res_nxt.pos[k] = 32'h80000000;
      end else begin
        res_nxt.pos[k] = s[31:0];
      end
      res_nxt.nrm[k] = 16'(rsh(72'(n3_r[k]), 16));
    end
    if (cfg.tex_en) begin
      res_nxt.ts = pole3_r ? TEX_HALF : ts3_r;
      res_nxt.tt = tt3_r;
    end
    res_nxt.err = err3_r;
    res_nxt.pole = pole3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data = res_r;

  // A pole has no horizontal normal component
  `ASSERT_CLK(a_pole_flat, (v4_r && res_r.pole) |-> (res_r.nrm[0] == 16'd0 && res_r.nrm[2] == 16'd0), "pole normal not vertical")
  // A pole has a unit vertical normal
  `ASSERT_CLK(a_pole_unit, (v4_r && res_r.pole) |-> (res_r.nrm[1] == 16'h4000 || res_r.nrm[1] == 16'hc000), "pole normal y not unit")
  // A pole texture s is one half or disabled
  `ASSERT_CLK(a_pole_tex, (v4_r && res_r.pole) |-> (res_r.ts == TEX_HALF || res_r.ts == 17'd0), "pole tex_s wrong")

endmodule

[sv/latlong_sphere_vertex_generator_top.sv]
// ----------------------------------------------------------------------------
// latlong_sphere_vertex_generator_top
// Normal, position and texture coordinates of one UV sphere vertex per beat.
// ----------------------------------------------------------------------------
// Takes one vertex per clock unless out_tready stalls the pipeline, and returns
// one result per vertex in order, through 33 divider cells (one quotient bit each, the
// phase quotients being 33 bits), one angle-scaling stage, 30 CORDIC cells
// (one rotation each) and 4 stages of products, rounding and saturation.
// Every stage has its own valid bit, so bubbles collapse under output stall.
// Configuration must be written only while no vertex is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module latlong_sphere_vertex_generator_top
  import lsvg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // ring_index[8:0], segment_index[18:9], zero pad
  input  logic [23:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // normal_x, normal_y, normal_z (16 each), pos_x, pos_y, pos_z (32 each),
  // tex_s, tex_t (17 each), zero pad
  output logic [183:0] out_tdata,
  // index_error
  output logic out_tuser
);

  cfg_t cfg_r;
  logic [8:0] nreg_r;
  logic [8:0] n;
  logic [8:0] ring;
  logic [9:0] seg;
  logic [9:0] n2;
  div_t d0;
  logic err;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.center_z <= '0;
      cfg_r.radius <= 31'd65536;
      cfg_r.tex_en <= 1'b1;
      nreg_r <= 9'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg_r.center_x <= cfg_wdata;
        REG_CENTER_Y: cfg_r.center_y <= cfg_wdata;
        REG_CENTER_Z: cfg_r.center_z <= cfg_wdata;
        REG_RADIUS: cfg_r.radius <= cfg_wdata[30:0];
        REG_SEG_COUNT: nreg_r <= cfg_wdata[8:0];
        REG_TEX_EN: cfg_r.tex_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp ring count and indices, build dividends
  always_comb begin
    logic [8:0] ri;
    logic [9:0] si;
    if (nreg_r < 9'd2) begin
      n = 9'd2;
    end else if ({4'd0, nreg_r} > 13'(SEG_MAX)) begin
      n = 9'(SEG_MAX);
    end else begin
      n = nreg_r;
    end
    n2 = {n, 1'b0};
    ri = in_tdata[8:0];
    si = in_tdata[18:9];
    err = (ri > n) || (si > n2);
    ring = (ri > n) ? n : ri;
    seg = (si > n2) ? n2 : si;
    d0.rem[0] = (DW'(ring) << 31) + DW'(n >> 1);
    d0.rem[1] = (DW'(seg) << 31) + DW'(n >> 1);
    d0.rem[2] = (DW'(seg) << 16) + DW'(n);
    d0.rem[3] = (DW'(ring) << 16) + DW'(n >> 1);
    d0.quo = '0;
    d0.n = n;
    d0.err = err;
    d0.pole = (ring == 9'd0) || (ring == n);
  end

  // Divider chain, most significant quotient bit first
  logic [QW:0] dv;
  logic [QW:0] dr;
  div_t dd [QW+1];
  assign dv[0] = in_tvalid;
  assign in_tready = dr[0];
  assign dd[0] = d0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    lsvg_div_cell #(.BIT(QW - 1 - k)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(dv[k]), .in_ready(dr[k]), .in_data(dd[k]),
      .out_valid(dv[k+1]), .out_ready(dr[k+1]), .out_data(dd[k+1])
    );
  end

  // Split phases and scale the angle remainder to radians
  logic pv_r;
  prep_t p_r;
  logic prdy;
  logic cr0;
  assign prdy = !pv_r || cr0;
  assign dr[QW] = prdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (prdy) begin
      pv_r <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (prdy && dv[QW]) begin
      for (int l = 0; l < 2; l++) begin
        p_r.quad[l] <= dd[QW].quo[l][31:30];
        p_r.zero[l] <= (dd[QW].quo[l][29:0] == 30'd0);
        p_r.zprod[l] <= PW'(dd[QW].quo[l][29:0]) * PW'(HALF_PI_Q30);
      end
      p_r.ts <= dd[QW].quo[2][16:0];
      p_r.tt <= dd[QW].quo[3][16:0];
      p_r.err <= dd[QW].err;
      p_r.pole <= dd[QW].pole;
    end
  end

  // Seed the CORDIC lanes
  cord_t c0;
  always_comb begin
    logic [PW-1:0] zr;
    c0 = '0;
    for (int l = 0; l < 2; l++) begin
      zr = p_r.zprod[l] + (PW'(1) << 29);
      c0.z[l] = ZW'(zr >> 30);
      c0.x[l] = GAIN_Q30;
      c0.y[l] = '0;
    end
    c0.quad = p_r.quad;
    c0.zero = p_r.zero;
    c0.ts = p_r.ts;
    c0.tt = p_r.tt;
    c0.err = p_r.err;
    c0.pole = p_r.pole;
  end

  logic [STEPS:0] cv;
  logic [STEPS:0] cr;
  cord_t cd [STEPS+1];
  assign cv[0] = pv_r;
  assign cr0 = cr[0];
  assign cd[0] = c0;

  for (genvar k = 0; k < STEPS; k++) begin : g_cordic
    lsvg_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(cv[k]), .in_ready(cr[k]), .in_data(cd[k]),
      .out_valid(cv[k+1]), .out_ready(cr[k+1]), .out_data(cd[k+1])
    );
  end

  res_t res;
  lsvg_post u_post (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(cv[STEPS]), .in_ready(cr[STEPS]), .in_data(cd[STEPS]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  // Pack the result beat
  assign out_tdata = {6'd0, res.tt, res.ts, res.pos[2], res.pos[1], res.pos[0],
                      res.nrm[2], res.nrm[1], res.nrm[0]};
  assign out_tuser = res.err;

endmodule
